/* hdl/dmru_pkg.sv */
// Shared types, constants and helpers for the double Monod rate update block.
package dmru_pkg;

    localparam int DATA_W = 32;
    localparam int ACC_W  = 40;
    localparam int CAP_W  = 37;
    localparam int IDX_W  = 3;

    localparam logic [CAP_W-1:0] CLAMP_CAP = CAP_W'(1) << (CAP_W - 1);

    typedef enum logic [IDX_W-1:0] {
        CFG_MAX_GROWTH  = 3'd0,
        CFG_YIELD       = 3'd1,
        CFG_MAINTENANCE = 3'd2,
        CFG_DECAY       = 3'd3,
        CFG_OXYGEN_HS   = 3'd4,
        CFG_NITRITE_HS  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] max_growth_rate;
        logic [DATA_W-1:0] yield_coef;
        logic [DATA_W-1:0] maintenance_rate;
        logic [DATA_W-1:0] decay_rate;
        logic [DATA_W-1:0] oxygen_half_sat;
        logic [DATA_W-1:0] nitrite_half_sat;
    } cfg_t;

    // Cell data that rides alongside the Monod dividers.
    typedef struct packed {
        logic [DATA_W-1:0]        dens;
        logic                     active;
        logic signed [DATA_W-1:0] acc_n;
        logic signed [DATA_W-1:0] acc_o;
        logic signed [DATA_W-1:0] acc_no3;
        logic                     dn_zero;
        logic                     do_zero;
    } pay1_t;

    // Cell data that rides alongside the yield divider.
    typedef struct packed {
        logic                     active;
        logic signed [DATA_W-1:0] acc_n;
        logic signed [DATA_W-1:0] acc_o;
        logic signed [DATA_W-1:0] acc_no3;
        logic [DATA_W-1:0]        spec;
        logic [CAP_W-1:0]         g;
        logic [CAP_W-1:0]         m;
        logic                     ovf;
        logic                     yzero;
    } pay2_t;

    function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [DATA_W-1:0] r;
        if (v > ACC_W'(signed'(33'sh07FFFFFFF))) begin
            r = 32'h7FFFFFFF;
        end else if (v < ACC_W'(signed'(33'sh180000000))) begin
            r = 32'h80000000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hdl/dmru_delay.sv */
// Enabled delay line that carries a packed payload for a fixed number of stages.
module dmru_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];
endmodule

/* hdl/dmru_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module dmru_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 33,
    parameter int Q_W   = 17
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);
    // The caller guarantees num >> Q_W < den, or discards the quotient.
    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   low_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_src;
        logic [DEN_W-1:0] den_src;
        logic [Q_W-1:0]   low_src;
        logic [Q_W-1:0]   quo_src;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_src = DEN_W'(num >> Q_W);
            assign den_src = den;
            assign low_src = num[Q_W-1:0];
            assign quo_src = '0;
        end else begin : g_next
            assign rem_src = rem_reg[k-1];
            assign den_src = den_reg[k-1];
            assign low_src = low_reg[k-1];
            assign quo_src = quo_reg[k-1];
        end

        assign trial = {rem_src, low_src[Q_W-1]};
        assign diff  = trial - {1'b0, den_src};
        assign ge    = (trial >= {1'b0, den_src});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                den_reg[k] <= den_src;
                low_reg[k] <= low_src << 1;
                quo_reg[k] <= {quo_src[Q_W-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[Q_W-1];
endmodule

/* hdl/dmru_cfg.sv */
// Configuration register file for the rate update block.
module dmru_cfg #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dmru_pkg::IDX_W-1:0]   cfg_index,
    input  logic [dmru_pkg::DATA_W-1:0]  cfg_data,
    output dmru_pkg::cfg_t               cfg
);
    // The yield coefficient comes out of reset as 1.0 in the active fixed-point format.
    localparam logic [dmru_pkg::DATA_W-1:0] YIELD_ONE =
        {{(dmru_pkg::DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    dmru_pkg::cfg_t cfg_reg;
    dmru_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (dmru_pkg::cfg_idx_t'(cfg_index))
                dmru_pkg::CFG_MAX_GROWTH:  cfg_next.max_growth_rate  = cfg_data;
                dmru_pkg::CFG_YIELD:       cfg_next.yield_coef       = cfg_data;
                dmru_pkg::CFG_MAINTENANCE: cfg_next.maintenance_rate = cfg_data;
                dmru_pkg::CFG_DECAY:       cfg_next.decay_rate       = cfg_data;
                dmru_pkg::CFG_OXYGEN_HS:   cfg_next.oxygen_half_sat  = cfg_data;
                dmru_pkg::CFG_NITRITE_HS:  cfg_next.nitrite_half_sat = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{yield_coef: YIELD_ONE, default: '0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

/* hdl/double_monod_rate_update.sv */
// Streaming double Monod rate update: one grid cell is accepted every clock cycle while the
// output is not stalled; the default FRAC_BITS of 16 gives Q16.16 values. The two dividers
// produce one quotient bit per pipeline stage: FRAC_BITS + 1 stages for the Monod ratios
// and 37 for the yield division. The whole pipeline advances
// together whenever the output register is empty or being taken, so a stall downstream
// holds every stage in place. Configuration writes are taken in one cycle at any time but
// must only be issued while no request is in flight; writes to unknown indexes are dropped.
module double_monod_rate_update #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dmru_pkg::DATA_W-1:0]         s_conc_nitrite,
    input  logic [dmru_pkg::DATA_W-1:0]         s_conc_oxygen,
    input  logic [dmru_pkg::DATA_W-1:0]         s_biomass_density,
    input  logic                                s_cell_active,
    input  logic signed [dmru_pkg::DATA_W-1:0]  s_acc_nitrite_in,
    input  logic signed [dmru_pkg::DATA_W-1:0]  s_acc_oxygen_in,
    input  logic signed [dmru_pkg::DATA_W-1:0]  s_acc_nitrate_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [dmru_pkg::DATA_W-1:0]  m_acc_nitrite_out,
    output logic signed [dmru_pkg::DATA_W-1:0]  m_acc_oxygen_out,
    output logic signed [dmru_pkg::DATA_W-1:0]  m_acc_nitrate_out,
    output logic signed [dmru_pkg::DATA_W-1:0]  m_specific_growth,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dmru_pkg::IDX_W-1:0]          cfg_index,
    input  logic [dmru_pkg::DATA_W-1:0]         cfg_data
);
    localparam int DW    = dmru_pkg::DATA_W;
    localparam int AW    = dmru_pkg::ACC_W;
    localparam int CW    = dmru_pkg::CAP_W;
    localparam int FN_W  = FRAC_BITS + 1;
    localparam int L1    = FN_W;
    localparam int LAST  = L1 + CW + 8;
    localparam int P1_W  = $bits(dmru_pkg::pay1_t);
    localparam int P2_W  = $bits(dmru_pkg::pay2_t);
    localparam logic [FN_W-1:0] C115 =
        FN_W'(((64'd115 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam int LO_W  = DW + FN_W;
    localparam int HI_W  = (CW - DW) + FN_W;
    localparam int SUM_W = CW + FN_W + 1;

    dmru_pkg::cfg_t cfg;
    logic           en;
    logic [LAST:0]  vld_reg;

    dmru_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign en      = !vld_reg[LAST] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAST-1:0], s_valid};
        end
    end

    // Input register.
    logic [DW-1:0]        cn_reg, co_reg, dens_reg;
    logic                 act_reg;
    logic signed [DW-1:0] an_reg, ao_reg, ano3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cn_reg   <= s_conc_nitrite;
            co_reg   <= s_conc_oxygen;
            dens_reg <= s_biomass_density;
            act_reg  <= s_cell_active;
            an_reg   <= s_acc_nitrite_in;
            ao_reg   <= s_acc_oxygen_in;
            ano3_reg <= s_acc_nitrate_in;
        end
    end

    logic [DW:0]         den_n, den_o;
    dmru_pkg::pay1_t     pay1_in, pay1_out;
    logic [FN_W-1:0]     qn, qo;

    assign den_n = {1'b0, cn_reg} + {1'b0, cfg.nitrite_half_sat};
    assign den_o = {1'b0, co_reg} + {1'b0, cfg.oxygen_half_sat};

    always_comb begin
        pay1_in.dens    = dens_reg;
        pay1_in.active  = act_reg;
        pay1_in.acc_n   = an_reg;
        pay1_in.acc_o   = ao_reg;
        pay1_in.acc_no3 = ano3_reg;
        pay1_in.dn_zero = (den_n == '0);
        pay1_in.do_zero = (den_o == '0);
    end

    dmru_div #(.NUM_W(DW + FRAC_BITS), .DEN_W(DW + 1), .Q_W(FN_W)) u_div_n (
        .aclk (aclk), .en (en), .num ({cn_reg, FRAC_BITS'(0)}), .den (den_n), .quo (qn)
    );
    dmru_div #(.NUM_W(DW + FRAC_BITS), .DEN_W(DW + 1), .Q_W(FN_W)) u_div_o (
        .aclk (aclk), .en (en), .num ({co_reg, FRAC_BITS'(0)}), .den (den_o), .quo (qo)
    );
    dmru_delay #(.W(P1_W), .DEPTH(L1)) u_dly1 (
        .aclk (aclk), .en (en), .d (pay1_in), .q (pay1_out)
    );

    // Stage A: first products of the Monod ratios.
    logic [FN_W-1:0]      fn, fo;
    logic [DW+FN_W-1:0]   mg_prod, mt_prod;
    logic [DW-1:0]        t1_reg, maint_a_reg;
    logic [FN_W-1:0]      fo_reg;
    dmru_pkg::pay1_t      a_pay_reg;

    assign fn      = pay1_out.dn_zero ? '0 : qn;
    assign fo      = pay1_out.do_zero ? '0 : qo;
    assign mg_prod = (DW+FN_W)'(cfg.max_growth_rate) * (DW+FN_W)'(fn);
    assign mt_prod = (DW+FN_W)'(cfg.maintenance_rate) * (DW+FN_W)'(fo);

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg      <= mg_prod[FRAC_BITS +: DW];
            maint_a_reg <= mt_prod[FRAC_BITS +: DW];
            fo_reg      <= fo;
            a_pay_reg   <= pay1_out;
        end
    end

    // Stage B: uptake.
    logic [DW+FN_W-1:0] up_prod;
    logic [DW-1:0]      up_reg, maint_b_reg;
    dmru_pkg::pay1_t    b_pay_reg;

    assign up_prod = (DW+FN_W)'(t1_reg) * (DW+FN_W)'(fo_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            up_reg      <= up_prod[FRAC_BITS +: DW];
            maint_b_reg <= maint_a_reg;
            b_pay_reg   <= a_pay_reg;
        end
    end

    // Stage C: density products and the specific growth rate.
    logic signed [AW-1:0] spec_sum;
    logic [2*DW-1:0]      p_reg, mm_reg;
    logic [DW-1:0]        spec_reg;
    dmru_pkg::pay1_t      c_pay_reg;

    assign spec_sum = signed'(AW'(up_reg)) - signed'(AW'(maint_b_reg))
                    - signed'(AW'(cfg.decay_rate));

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg     <= (2*DW)'(up_reg) * (2*DW)'(b_pay_reg.dens);
            mm_reg    <= (2*DW)'(maint_b_reg) * (2*DW)'(b_pay_reg.dens);
            spec_reg  <= dmru_pkg::sat32(spec_sum);
            c_pay_reg <= b_pay_reg;
        end
    end

    // Stage D: clamps and yield division setup.
    logic [2*DW-1:0]  g_full, m_full;
    logic [2*DW-1:0]  p_d_reg;
    dmru_pkg::pay2_t  pay2_next, pay2_reg, pay2_out;
    logic [CW-1:0]    q2;

    assign g_full = p_reg >> FRAC_BITS;
    assign m_full = mm_reg >> FRAC_BITS;

    always_comb begin
        pay2_next.active  = c_pay_reg.active;
        pay2_next.acc_n   = c_pay_reg.acc_n;
        pay2_next.acc_o   = c_pay_reg.acc_o;
        pay2_next.acc_no3 = c_pay_reg.acc_no3;
        pay2_next.spec    = spec_reg;
        pay2_next.g       = (g_full > (2*DW)'(dmru_pkg::CLAMP_CAP)) ?
                            dmru_pkg::CLAMP_CAP : g_full[CW-1:0];
        pay2_next.m       = (m_full > (2*DW)'(dmru_pkg::CLAMP_CAP)) ?
                            dmru_pkg::CLAMP_CAP : m_full[CW-1:0];
        // A quotient of 2^37 or more is clamped anyway, so the divider only makes 37 bits.
        pay2_next.ovf     = (p_reg >> CW) >= (2*DW)'(cfg.yield_coef);
        pay2_next.yzero   = (cfg.yield_coef == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_d_reg  <= p_reg;
            pay2_reg <= pay2_next;
        end
    end

    dmru_div #(.NUM_W(2*DW), .DEN_W(DW), .Q_W(CW)) u_div_y (
        .aclk (aclk), .en (en), .num (p_d_reg), .den (cfg.yield_coef), .quo (q2)
    );
    dmru_delay #(.W(P2_W), .DEPTH(CW)) u_dly2 (
        .aclk (aclk), .en (en), .d (pay2_reg), .q (pay2_out)
    );

    // Stage E: nitrite consumption.
    logic [CW-1:0]   n_e_reg;
    dmru_pkg::pay2_t e_pay_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (pay2_out.yzero) begin
                n_e_reg <= '0;
            end else if (pay2_out.ovf || (q2 > dmru_pkg::CLAMP_CAP)) begin
                n_e_reg <= dmru_pkg::CLAMP_CAP;
            end else begin
                n_e_reg <= q2;
            end
            e_pay_reg <= pay2_out;
        end
    end

    // Stage F: partial products of 1.15 * n.
    logic [LO_W-1:0] lo_reg;
    logic [HI_W-1:0] hi_reg;
    logic [CW-1:0]   n_f_reg;
    dmru_pkg::pay2_t f_pay_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg    <= LO_W'(n_e_reg[DW-1:0]) * LO_W'(C115);
            hi_reg    <= HI_W'(n_e_reg[CW-1:DW]) * HI_W'(C115);
            n_f_reg   <= n_e_reg;
            f_pay_reg <= e_pay_reg;
        end
    end

    // Stage G: oxygen yield term.
    logic [SUM_W-1:0]     c115_sum;
    logic [CW:0]          c115n;
    logic signed [AW-1:0] oxy_reg;
    logic [CW-1:0]        n_g_reg;
    dmru_pkg::pay2_t      g_pay_reg;

    assign c115_sum = SUM_W'(lo_reg) + (SUM_W'(hi_reg) << DW);
    assign c115n    = c115_sum[FRAC_BITS +: CW+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            oxy_reg   <= f_pay_reg.yzero ? '0 :
                         signed'(AW'(c115n)) - signed'(AW'(f_pay_reg.g));
            n_g_reg   <= n_f_reg;
            g_pay_reg <= f_pay_reg;
        end
    end

    // Output register: accumulator updates and saturation.
    logic signed [AW-1:0] an_ext, ao_ext, ano3_ext, n_ext;
    logic signed [AW-1:0] an_next, ao_next, ano3_next;
    logic [DW-1:0]        out_n_reg, out_o_reg, out_no3_reg, out_spec_reg;

    assign an_ext   = AW'(g_pay_reg.acc_n);
    assign ao_ext   = AW'(g_pay_reg.acc_o);
    assign ano3_ext = AW'(g_pay_reg.acc_no3);
    assign n_ext    = signed'(AW'(n_g_reg));

    always_comb begin
        if (g_pay_reg.active) begin
            an_next   = an_ext - n_ext;
            ao_next   = ao_ext - oxy_reg - signed'(AW'(g_pay_reg.m));
            ano3_next = ano3_ext + n_ext;
        end else begin
            an_next   = an_ext;
            ao_next   = ao_ext;
            ano3_next = ano3_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_n_reg    <= dmru_pkg::sat32(an_next);
            out_o_reg    <= dmru_pkg::sat32(ao_next);
            out_no3_reg  <= dmru_pkg::sat32(ano3_next);
            out_spec_reg <= g_pay_reg.spec;
        end
    end

    assign m_acc_nitrite_out = signed'(out_n_reg);
    assign m_acc_oxygen_out  = signed'(out_o_reg);
    assign m_acc_nitrate_out = signed'(out_no3_reg);
    assign m_specific_growth = signed'(out_spec_reg);
endmodule
